// ===== rtl/lerb_pkg.sv =====
`timescale 1ns / 1ps
// Package for the line evicting ring buffer: request/response payload types,
// action codes, FSM state codes and the newline constant. No dependencies.
package lerb_pkg;

    typedef enum logic [1:0] {
        ACT_APPEND  = 2'd0,
        ACT_RESERVE = 2'd1,
        ACT_READ    = 2'd2,
        ACT_CLEAR   = 2'd3
    } lerb_action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVICT
    } lerb_state_t;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    typedef struct packed {
        lerb_action_t action;
        logic [7:0]   byte_value;
        logic [15:0]  message_length;
        logic [11:0]  read_offset;
    } lerb_req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        read_valid;
        logic [12:0] fill_level;
    } lerb_rsp_t;

endpackage

// ===== rtl/lerb_chan_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one request or response payload.
// Payload type comes from lerb_pkg through the type parameter.
interface lerb_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/line_evicting_ring_buffer.sv =====
`timescale 1ns / 1ps
// Line evicting byte ring buffer; uses lerb_pkg and lerb_chan_if.
// Append and clear: response registered from the request; one request per cycle while
// responses are taken. Read: in range, registered memory read then response register; out
// of range, response register only; next request no earlier than the edge handing over the
// response. Reserve: direct if it fits, else evicts oldest lines bytewise (one read port).
// Reset clears pointers, fill count and skip count; the byte memory is not cleared.
module line_evicting_ring_buffer #(
    parameter int RING_DEPTH = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    lerb_chan_if.sink         req,
    lerb_chan_if.source       rsp
);
    import lerb_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int MW = (CW > 12) ? CW : 12;
    localparam logic [AW:0]   DEPTH_A = (AW + 1)'(RING_DEPTH);
    localparam logic [CW:0]   DEPTH_C = (CW + 1)'(RING_DEPTH);
    localparam logic [16:0]   DEPTH_L = 17'(RING_DEPTH);
    localparam logic [16:0]   DEPTH_M1_L = 17'(RING_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_M1_C = CW'(RING_DEPTH - 1);

    function automatic logic [AW-1:0] wrap(input logic [AW:0] a);
        logic [AW:0] s;
        s = (a >= DEPTH_A) ? (a - DEPTH_A) : a;
        return s[AW-1:0];
    endfunction

    function automatic logic fits(input logic [CW-1:0] f, input logic [CW-1:0] l);
        return ((CW + 1)'(f) + (CW + 1)'(l)) <= DEPTH_C;
    endfunction

    logic [7:0] mem [RING_DEPTH];
    logic [7:0] mem_q;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic [AW-1:0] mem_ra;

    lerb_state_t   state_reg, state_next;
    logic [AW-1:0] oldest_reg, oldest_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [15:0]   skip_reg, skip_next;
    logic [CW-1:0] len_reg, len_next;
    logic          ov_reg, ov_next;
    lerb_rsp_t     rsp_reg, rsp_next;

    logic          accept;
    logic          rsp_load;
    lerb_rsp_t     rsp_val;
    logic [CW-1:0] clen;
    logic [CW-1:0] fill_dec;
    logic          end_line;

    assign req.ready   = (state_reg == ST_IDLE) && (!ov_reg || rsp.ready);
    assign accept      = req.valid && req.ready;
    assign rsp.valid   = ov_reg;
    assign rsp.payload = rsp_reg;
    assign fill_dec    = fill_reg - CW'(1);
    assign end_line    = (mem_q == NEWLINE_BYTE) || (fill_reg == CW'(1));

    always_comb
    begin
        state_next  = state_reg;
        oldest_next = oldest_reg;
        fill_next   = fill_reg;
        skip_next   = skip_reg;
        len_next    = len_reg;
        mem_we      = 1'b0;
        mem_wa      = wrap((AW + 1)'(oldest_reg) + (AW + 1)'(fill_reg));
        mem_wd      = req.payload.byte_value;
        mem_ra      = oldest_reg;
        rsp_load    = 1'b0;
        rsp_val     = '0;
        clen        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.payload.action)
                        ACT_APPEND:
                        begin
                            if (skip_reg != 16'd0)
                            begin
                                skip_next = skip_reg - 16'd1;
                            end
                            else if ((CW + 1)'(fill_reg) < DEPTH_C)
                            begin
                                mem_we    = 1'b1;
                                fill_next = fill_reg + CW'(1);
                            end
                            rsp_load           = 1'b1;
                            rsp_val.fill_level = 13'(fill_next);
                        end
                        ACT_RESERVE:
                        begin
                            if (17'(req.payload.message_length) >= DEPTH_L)
                            begin
                                skip_next = 16'(17'(req.payload.message_length) - DEPTH_M1_L);
                                clen      = DEPTH_M1_C;
                            end
                            else
                            begin
                                skip_next = 16'd0;
                                clen      = CW'(req.payload.message_length);
                            end
                            len_next = clen;
                            if (fits(fill_reg, clen))
                            begin
                                rsp_load           = 1'b1;
                                rsp_val.fill_level = 13'(fill_reg);
                            end
                            else
                            begin
                                state_next = ST_EVICT;
                            end
                        end
                        ACT_READ:
                        begin
                            mem_ra = wrap((AW + 1)'(oldest_reg)
                                          + (AW + 1)'(req.payload.read_offset));
                            if (MW'(req.payload.read_offset) < MW'(fill_reg))
                            begin
                                state_next = ST_READ;
                            end
                            else
                            begin
                                rsp_load           = 1'b1;
                                rsp_val.fill_level = 13'(fill_reg);
                            end
                        end
                        ACT_CLEAR:
                        begin
                            oldest_next        = '0;
                            fill_next          = '0;
                            rsp_load           = 1'b1;
                            rsp_val.fill_level = 13'd0;
                        end
                        default:
                        begin
                            rsp_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                rsp_load           = 1'b1;
                rsp_val.read_data  = mem_q;
                rsp_val.read_valid = 1'b1;
                rsp_val.fill_level = 13'(fill_reg);
                state_next         = ST_IDLE;
            end
            ST_EVICT:
            begin
                // pop the oldest byte, prefetch the one after it
                mem_ra      = wrap((AW + 1)'(oldest_reg) + (AW + 1)'(1));
                oldest_next = mem_ra;
                fill_next   = fill_dec;
                if (end_line && fits(fill_dec, len_reg))
                begin
                    rsp_load           = 1'b1;
                    rsp_val.fill_level = 13'(fill_dec);
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        ov_next  = rsp_load ? 1'b1 : (rsp.ready ? 1'b0 : ov_reg);
        rsp_next = rsp_load ? rsp_val : rsp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            oldest_reg <= '0;
            fill_reg   <= '0;
            skip_reg   <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            oldest_reg <= oldest_next;
            fill_reg   <= fill_next;
            skip_reg   <= skip_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        mem_q <= mem[mem_ra];
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (CW + 1)'(fill_reg) <= DEPTH_C)
        else $error("fill count above ring depth");

    a_oldest_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (AW + 1)'(oldest_reg) < DEPTH_A)
        else $error("oldest index out of range");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req.ready)
        else $error("request taken while busy");

    a_request_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (rsp.valid || state_reg == ST_READ
                                      || state_reg == ST_EVICT))
        else $error("request produced no response and no work");

    a_evict_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVICT) |=> (fill_reg < $past(fill_reg)))
        else $error("eviction did not remove a byte");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for line_evicting_ring_buffer: a directed script, then random
// message traffic under four handshake idling mixes. Needs lerb_pkg and lerb_chan_if.
module tb_top;
    import lerb_pkg::*;

    localparam int RING_DEPTH = 4096;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASE_ITEMS = 500;

    typedef struct packed {
        lerb_req_t req;
        logic      pinned;
        lerb_rsp_t rsp;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n;

    lerb_chan_if #(.payload_t(lerb_req_t)) req_if ();
    lerb_chan_if #(.payload_t(lerb_rsp_t)) rsp_if ();

    line_evicting_ring_buffer #(.RING_DEPTH(RING_DEPTH)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // shadow copy of the ring
    logic [7:0]  shadow_bytes [RING_DEPTH];
    logic [11:0] shadow_head;
    logic [12:0] shadow_fill;
    logic [15:0] shadow_skip;

    lerb_rsp_t   awaited_rsp [$];
    lerb_rsp_t   want;
    script_row_t script [$];
    int          errors = 0;
    int          cycle_count = 0;
    int          items_sent = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (awaited_rsp.size() == 0)
            begin
                $display("%0t: unexpected response data %h valid %b fill %0d", $time,
                         rsp_if.payload.read_data, rsp_if.payload.read_valid,
                         rsp_if.payload.fill_level);
                errors++;
            end
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp_if.payload.read_data !== want.read_data)
                begin
                    $display("%0t: read_data expected %h actual %h", $time,
                             want.read_data, rsp_if.payload.read_data);
                    errors++;
                end
                if (rsp_if.payload.read_valid !== want.read_valid)
                begin
                    $display("%0t: read_valid expected %b actual %b", $time,
                             want.read_valid, rsp_if.payload.read_valid);
                    errors++;
                end
                if (rsp_if.payload.fill_level !== want.fill_level)
                begin
                    $display("%0t: fill_level expected %0d actual %0d", $time,
                             want.fill_level, rsp_if.payload.fill_level);
                    errors++;
                end
            end
        end
    end

    function automatic lerb_rsp_t predict_ring_access(lerb_req_t r);
        lerb_rsp_t   o;
        logic [12:0] len;
        logic [12:0] n;
        logic [11:0] idx;
        logic        hit;
        o = '0;
        case (r.action)
            ACT_APPEND:
            begin
                if (shadow_skip != 0)
                    shadow_skip = shadow_skip - 1'b1;
                else if (shadow_fill < RING_DEPTH)
                begin
                    idx = shadow_head + shadow_fill[11:0];
                    shadow_bytes[idx] = r.byte_value;
                    shadow_fill = shadow_fill + 1'b1;
                end
            end
            ACT_RESERVE:
            begin
                if (r.message_length >= RING_DEPTH)
                begin
                    shadow_skip = 16'(r.message_length - (RING_DEPTH - 1));
                    len = 13'(RING_DEPTH - 1);
                end
                else
                begin
                    shadow_skip = '0;
                    len = r.message_length[12:0];
                end
                // drop oldest lines, newline included, until the message fits
                while (shadow_fill + len > RING_DEPTH)
                begin
                    n = '0;
                    hit = 1'b0;
                    while (n < shadow_fill && !hit)
                    begin
                        idx = shadow_head + n[11:0];
                        hit = (shadow_bytes[idx] == NEWLINE_BYTE);
                        n = n + 1'b1;
                    end
                    shadow_head = shadow_head + n[11:0];
                    shadow_fill = shadow_fill - n;
                end
            end
            ACT_READ:
            begin
                if (r.read_offset < shadow_fill)
                begin
                    idx = shadow_head + r.read_offset;
                    o.read_valid = 1'b1;
                    o.read_data = shadow_bytes[idx];
                end
            end
            ACT_CLEAR:
            begin
                shadow_head = '0;
                shadow_fill = '0;
            end
            default:
            begin
            end
        endcase
        o.fill_level = shadow_fill;
        return o;
    endfunction

    function automatic script_row_t script_row(lerb_action_t a, logic [7:0] b,
                                               logic [15:0] len, logic [11:0] off,
                                               logic pinned, logic [7:0] rd,
                                               logic rv, logic [12:0] fl);
        script_row_t s;
        s.req.action = a;
        s.req.byte_value = b;
        s.req.message_length = len;
        s.req.read_offset = off;
        s.pinned = pinned;
        s.rsp.read_data = rd;
        s.rsp.read_valid = rv;
        s.rsp.fill_level = fl;
        return s;
    endfunction

    function automatic lerb_req_t rand_req(lerb_action_t a);
        lerb_req_t r;
        r.action = a;
        r.byte_value = 8'($urandom_range(255));
        r.message_length = 16'($urandom_range(65535));
        r.read_offset = 12'($urandom_range(4095));
        return r;
    endfunction

    function automatic logic [7:0] text_byte(int nl_odds);
        logic [7:0] b;
        if ($urandom_range(nl_odds - 1) == 0)
            b = NEWLINE_BYTE;
        else
            b = 8'($urandom_range(255));
        return b;
    endfunction

    task automatic issue(lerb_req_t r, logic pinned, lerb_rsp_t pinned_rsp);
        lerb_rsp_t calc;
        while ($urandom_range(99) < gap_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.payload <= r;
        do
            @(posedge clk);
        while (!req_if.ready);
        calc = predict_ring_access(r);
        awaited_rsp.push_back(pinned ? pinned_rsp : calc);
        items_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        lerb_req_t r;
        r = rand_req(ACT_APPEND);
        r.byte_value = b;
        issue(r, 1'b0, '0);
    endtask

    task automatic send_reserve(int len);
        lerb_req_t r;
        r = rand_req(ACT_RESERVE);
        r.message_length = len[15:0];
        issue(r, 1'b0, '0);
    endtask

    task automatic send_read();
        lerb_req_t r;
        r = rand_req(ACT_READ);
        // mostly inside the stored text, edge at fill level included unless the ring is full
        if (shadow_fill != 0 && $urandom_range(3) != 0)
            r.read_offset = 12'($urandom_range(shadow_fill == RING_DEPTH ? RING_DEPTH - 1
                                                                           : shadow_fill));
        issue(r, 1'b0, '0);
    endtask

    task automatic send_message(int len, int count);
        int i;
        send_reserve(len);
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 15)
                send_read();
            send_byte((i == len - 1) ? NEWLINE_BYTE : text_byte(12));
        end
    endtask

    task automatic fill_to_capacity(int nl_odds);
        int k;
        send_reserve(0);
        while (shadow_fill < RING_DEPTH)
            send_byte(text_byte(nl_odds));
        for (k = 0; k < 3; k++)
            send_byte(text_byte(nl_odds));
        for (k = 0; k < 4; k++)
            send_read();
        send_reserve($urandom_range(1, RING_DEPTH - 1));
    endtask

    task automatic random_episode();
        int k;
        int len;
        k = $urandom_range(99);
        if (k < 60)
        begin
            len = $urandom_range(1, 120);
            send_message(len, len);
        end
        else if (k < 66)
        begin
            len = $urandom_range(RING_DEPTH, RING_DEPTH + 64);
            send_message(len, len - (RING_DEPTH - 1) + $urandom_range(0, 40));
        end
        else if (k < 72)
        begin
            len = $urandom_range(2000, RING_DEPTH - 1);
            send_message(len, $urandom_range(0, 60));
        end
        else if (k < 76)
        begin
            len = $urandom_range(1, 120);
            send_message(len, $urandom_range(0, len - 1));
        end
        else if (k < 88)
            send_read();
        else if (k < 91)
            issue(rand_req(ACT_CLEAR), 1'b0, '0);
        else
            issue(rand_req(lerb_action_t'($urandom_range(3))), 1'b0, '0);
    endtask

    initial
    begin
        int p;
        int start;
        rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.payload <= '0;
        shadow_head = '0;
        shadow_fill = '0;
        shadow_skip = '0;

        script.push_back(script_row(ACT_READ,    8'h00, 16'd0,     12'h000, 1'b1, 8'h00, 1'b0,
                                    13'd0));
        script.push_back(script_row(ACT_APPEND,  8'hFF, 16'd0,     12'h000, 1'b1, 8'h00, 1'b0,
                                    13'd1));
        script.push_back(script_row(ACT_APPEND,  8'h00, 16'd0,     12'h000, 1'b1, 8'h00, 1'b0,
                                    13'd2));
        script.push_back(script_row(ACT_APPEND,  NEWLINE_BYTE, 16'd0, 12'h000, 1'b1, 8'h00, 1'b0,
                                    13'd3));
        script.push_back(script_row(ACT_READ,    8'h00, 16'd0,     12'h000, 1'b0, 8'h00, 1'b0,
                                    13'd0));
        script.push_back(script_row(ACT_READ,    8'h00, 16'd0,     12'h002, 1'b0, 8'h00, 1'b0,
                                    13'd0));
        script.push_back(script_row(ACT_READ,    8'h00, 16'd0,     12'hFFF, 1'b1, 8'h00, 1'b0,
                                    13'd3));
        script.push_back(script_row(ACT_READ,    8'h00, 16'd0,     12'h003, 1'b1, 8'h00, 1'b0,
                                    13'd3));
        script.push_back(script_row(ACT_APPEND,  8'h41, 16'd0,     12'h000, 1'b0, 8'h00, 1'b0,
                                    13'd0));
        script.push_back(script_row(ACT_APPEND,  NEWLINE_BYTE, 16'd0, 12'h000, 1'b0, 8'h00, 1'b0,
                                    13'd0));
        script.push_back(script_row(ACT_RESERVE, 8'h00, 16'd0,     12'h000, 1'b0, 8'h00, 1'b0,
                                    13'd0));
        script.push_back(script_row(ACT_RESERVE, 8'h00, 16'd4094,  12'h000, 1'b0, 8'h00, 1'b0,
                                    13'd0));
        script.push_back(script_row(ACT_RESERVE, 8'h00, 16'hFFFF,  12'h000, 1'b0, 8'h00, 1'b0,
                                    13'd0));
        script.push_back(script_row(ACT_APPEND,  8'h55, 16'd0,     12'h000, 1'b1, 8'h00, 1'b0,
                                    13'd0));
        script.push_back(script_row(ACT_RESERVE, 8'h00, 16'd4096,  12'h000, 1'b0, 8'h00, 1'b0,
                                    13'd0));
        script.push_back(script_row(ACT_APPEND,  8'h12, 16'd0,     12'h000, 1'b1, 8'h00, 1'b0,
                                    13'd0));
        script.push_back(script_row(ACT_APPEND,  8'h34, 16'd0,     12'h000, 1'b0, 8'h00, 1'b0,
                                    13'd0));
        script.push_back(script_row(ACT_APPEND,  8'h56, 16'd0,     12'h000, 1'b0, 8'h00, 1'b0,
                                    13'd0));
        script.push_back(script_row(ACT_RESERVE, 8'h00, 16'd4095,  12'h000, 1'b0, 8'h00, 1'b0,
                                    13'd0));
        script.push_back(script_row(ACT_APPEND,  8'hAA, 16'd0,     12'h000, 1'b0, 8'h00, 1'b0,
                                    13'd0));
        script.push_back(script_row(ACT_RESERVE, 8'h00, 16'd4100,  12'h000, 1'b0, 8'h00, 1'b0,
                                    13'd0));
        script.push_back(script_row(ACT_CLEAR,   8'h00, 16'd0,     12'h000, 1'b1, 8'h00, 1'b0,
                                    13'd0));
        script.push_back(script_row(ACT_APPEND,  8'h77, 16'd0,     12'h000, 1'b0, 8'h00, 1'b0,
                                    13'd0));
        script.push_back(script_row(ACT_RESERVE, 8'h00, 16'd1,     12'h000, 1'b0, 8'h00, 1'b0,
                                    13'd0));
        script.push_back(script_row(ACT_APPEND,  8'h77, 16'd0,     12'h000, 1'b0, 8'h00, 1'b0,
                                    13'd0));
        script.push_back(script_row(ACT_READ,    8'h00, 16'd0,     12'h000, 1'b0, 8'h00, 1'b0,
                                    13'd0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            issue(script[i].req, script[i].pinned, script[i].rsp);

        for (p = 0; p < 4; p++)
        begin
            case (p)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 75; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 75; end
                default: begin gap_pct = 15; stall_pct = 15; end
            endcase
            if (p == 0)
                fill_to_capacity(12);
            else if (p == 2)
                fill_to_capacity(400);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
                random_episode();
        end

        req_if.valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lerb_pkg.sv
rtl/lerb_chan_if.sv
rtl/line_evicting_ring_buffer.sv
bench/tb_top.sv
